// ===== hw/rtl/hfcp_pkg.sv =====
// Shared types, codes and constants for the host frame capture parser.
package hfcp_pkg;

  localparam logic [7:0] CODE_MATMUL = 8'hF0;
  localparam logic [7:0] CODE_PROBE  = 8'hF1;
  localparam logic [7:0] CODE_FILL   = 8'hFF;
  localparam logic [7:0] HDR_SIZE    = 8'd9;
  localparam logic [7:0] HCOUNT_MAX  = 8'd255;
  localparam logic [16:0] STREAM_LIMIT = 17'd253;
  localparam logic [7:0] COLS_LIMIT  = 8'd127;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [16:0] WEIGHT_CAP_RST = 17'd65536;
  localparam logic [14:0] ACT_CAP_RST    = 15'd16384;
  localparam logic [10:0] BIAS_CAP_RST   = 11'd1024;
  localparam logic [15:0] OUT_CAP_RST    = 16'd32768;

  typedef enum logic [1:0] {
    REG_WEIGHT_CAP = 2'd0,
    REG_ACT_CAP    = 2'd1,
    REG_BIAS_CAP   = 2'd2,
    REG_OUT_CAP    = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_FORWARD    = 3'd1,
    ACT_PROBE      = 3'd2,
    ACT_HDR_ERR    = 3'd3,
    ACT_BULK_START = 3'd4,
    ACT_STORE      = 3'd5,
    ACT_DRAIN      = 3'd6,
    ACT_BULK_DONE  = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    PH_CMD = 2'd0,
    PH_LEN = 2'd1,
    PH_PAY = 2'd2
  } phase_t;

  localparam logic [1:0] REGION_WEIGHTS = 2'd0;
  localparam logic [1:0] REGION_BIAS    = 2'd1;
  localparam logic [1:0] REGION_ACTS    = 2'd2;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } hfcp_in_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  out_byte;
    logic [1:0]  region;
    logic [15:0] offset;
    logic        pass;
    logic [15:0] dim_m;
    logic [15:0] dim_k;
    logic [15:0] dim_n;
    logic [7:0]  tile_rows;
    logic [7:0]  tile_cols;
    logic [7:0]  tile_m;
  } hfcp_out_t;

  typedef struct packed {
    logic       timeout;
    logic       fill;
    logic       matmul;
    logic       probe;
    logic [7:0] data;
  } hfcp_qitem_t;

  typedef struct packed {
    logic [16:0] weight_cap;
    logic [14:0] act_cap;
    logic [10:0] bias_cap;
    logic [15:0] out_cap;
  } hfcp_caps_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] wlen;
    logic [32:0] wblen;
    logic [33:0] exp_m1;
  } hfcp_dims_t;

endpackage

// ===== hw/rtl/hfcp_front.sv =====
// Input side: accepts beats, classifies them and buffers them in a short queue.
module hfcp_front import hfcp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  hfcp_in_t    in_item,
  output logic        q_valid,
  input  logic        q_pop,
  output hfcp_qitem_t q_item
);

  hfcp_qitem_t             slots [QDEPTH];
  logic [QPTR_W-1:0]       wr_ptr;
  logic [QPTR_W-1:0]       rd_ptr;
  logic [QPTR_W:0]         count;
  hfcp_qitem_t             cls;
  logic                    push;

  always_comb begin
    cls.timeout = in_item.cmd;
    cls.fill    = (in_item.data_byte == CODE_FILL);
    cls.matmul  = (in_item.data_byte == CODE_MATMUL);
    cls.probe   = (in_item.data_byte == CODE_PROBE);
    cls.data    = in_item.data_byte;
  end

  assign in_ready = (count != (QPTR_W+1)'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/hfcp_dims.sv =====
// Two-stage pipeline that sizes the bulk payload and checks the header dims.
module hfcp_dims import hfcp_pkg::*; (
  input  logic             clk,
  input  logic [0:8][7:0]  hdr,
  input  hfcp_caps_t       caps,
  output hfcp_dims_t       dims
);

  logic [15:0] m, k, n;
  logic [31:0] w_prod, a_prod, mn_prod;
  logic [15:0] rc_prod, mr_prod;
  logic [16:0] n2;
  logic        nz;
  logic        cols_ok;

  assign m = {hdr[1], hdr[0]};
  assign k = {hdr[3], hdr[2]};
  assign n = {hdr[5], hdr[4]};

  // Stage one: the products.
  always_ff @(posedge clk) begin
    w_prod  <= k * n;
    a_prod  <= m * k;
    mn_prod <= m * n;
    rc_prod <= hdr[6] * hdr[7];
    mr_prod <= hdr[8] * hdr[6];
    n2      <= {n, 1'b0};
    nz      <= (m != '0) && (k != '0) && (n != '0) && (hdr[6] != '0) &&
               (hdr[7] != '0) && (hdr[8] != '0);
    cols_ok <= (hdr[7] <= COLS_LIMIT);
  end

  // Stage two: limits, caps and the region boundaries.
  always_ff @(posedge clk) begin
    dims.ok <= nz && cols_ok &&
               (({1'b0, rc_prod} + {1'b0, mr_prod}) <= STREAM_LIMIT) &&
               (w_prod <= {15'd0, caps.weight_cap}) &&
               (a_prod <= {17'd0, caps.act_cap}) &&
               (n2 <= {6'd0, caps.bias_cap}) &&
               ({mn_prod, 1'b0} <= {17'd0, caps.out_cap});
    dims.wlen   <= w_prod;
    dims.wblen  <= {1'b0, w_prod} + {16'd0, n2};
    dims.exp_m1 <= {2'b0, w_prod} + {17'd0, n2} + {2'b0, a_prod};
  end

endmodule

// ===== hw/rtl/hfcp_back.sv =====
// Back end: frame tracking, header capture, bulk routing and the result register.
module hfcp_back import hfcp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  hfcp_qitem_t q_item,
  output logic        q_pop,
  input  hfcp_caps_t  caps,
  output logic        out_valid,
  input  logic        out_ready,
  output hfcp_out_t   out_item
);

  phase_t          phase, phase_next;
  logic            captured, captured_next;
  logic            cur_probe, cur_probe_next;
  logic [7:0]      bytes_left, bytes_left_next;
  logic [0:8][7:0] hdr;
  logic [7:0]      hcount, hcount_next;
  logic            bulk_running, bulk_running_next;
  logic            dims_ok, dims_ok_next;
  logic [31:0]     wlen, wlen_next;
  logic [32:0]     wblen, wblen_next;
  logic [33:0]     exp_m1, exp_m1_next;
  logic [33:0]     received, received_next;
  logic [7:0]      sum, sum_next;
  logic [1:0]      wcnt, wcnt_next;

  hfcp_dims_t      dims;
  hfcp_out_t       res;
  logic            can_load, load, emit_start, fin, hdr_we;
  logic [33:0]     off_rel;

  hfcp_dims u_dims (
    .clk  (clk),
    .hdr  (hdr),
    .caps (caps),
    .dims (dims)
  );

  assign can_load   = !out_valid || out_ready;
  assign emit_start = (wcnt == 2'd1) && can_load;
  assign q_pop      = q_valid && can_load && (wcnt == 2'd0);

  always_comb begin
    phase_next        = phase;
    captured_next     = captured;
    cur_probe_next    = cur_probe;
    bytes_left_next   = bytes_left;
    hcount_next       = hcount;
    bulk_running_next = bulk_running;
    dims_ok_next      = dims_ok;
    wlen_next         = wlen;
    wblen_next        = wblen;
    exp_m1_next       = exp_m1;
    received_next     = received;
    sum_next          = sum;
    wcnt_next         = wcnt;
    res               = '0;
    res.action        = ACT_NONE;
    load              = 1'b0;
    fin               = 1'b0;
    hdr_we            = 1'b0;
    off_rel           = '0;

    if (emit_start) begin
      load              = 1'b1;
      wcnt_next         = 2'd0;
      res.action        = ACT_BULK_START;
      res.pass          = dims.ok;
      res.dim_m         = {hdr[1], hdr[0]};
      res.dim_k         = {hdr[3], hdr[2]};
      res.dim_n         = {hdr[5], hdr[4]};
      res.tile_rows     = hdr[6];
      res.tile_cols     = hdr[7];
      res.tile_m        = hdr[8];
      bulk_running_next = 1'b1;
      dims_ok_next      = dims.ok;
      wlen_next         = dims.wlen;
      wblen_next        = dims.wblen;
      exp_m1_next       = dims.exp_m1;
      received_next     = '0;
      sum_next          = '0;
    end else if (wcnt > 2'd1) begin
      wcnt_next = wcnt - 2'd1;
    end else if (q_pop) begin
      load = 1'b1;
      if (q_item.timeout) begin
        bulk_running_next = 1'b0;
        phase_next        = PH_CMD;
      end else if (bulk_running) begin
        received_next = received + 34'd1;
        if (received < exp_m1) begin
          sum_next = sum + q_item.data;
          if (dims_ok) begin
            res.action   = ACT_STORE;
            res.out_byte = q_item.data;
            if (received < {2'b0, wlen}) begin
              res.region = REGION_WEIGHTS;
              off_rel    = received;
            end else if (received < {1'b0, wblen}) begin
              res.region = REGION_BIAS;
              off_rel    = received - {2'b0, wlen};
            end else begin
              res.region = REGION_ACTS;
              off_rel    = received - {1'b0, wblen};
            end
            res.offset = off_rel[15:0];
          end else begin
            res.action = ACT_DRAIN;
          end
        end else begin
          bulk_running_next = 1'b0;
          res.action        = ACT_BULK_DONE;
          res.pass          = dims_ok && (sum == q_item.data);
        end
      end else begin
        unique case (phase)
          PH_LEN: begin
            bytes_left_next = q_item.data;
            hcount_next     = '0;
            if (!captured) begin
              res.action   = ACT_FORWARD;
              res.out_byte = q_item.data;
            end
            if (q_item.data == 8'd0) begin
              phase_next = PH_CMD;
              fin        = captured;
            end else begin
              phase_next = PH_PAY;
            end
          end
          PH_PAY: begin
            if (captured) begin
              hdr_we = (hcount < HDR_SIZE);
              if (hcount != HCOUNT_MAX) begin
                hcount_next = hcount + 8'd1;
              end
            end else begin
              res.action   = ACT_FORWARD;
              res.out_byte = q_item.data;
            end
            bytes_left_next = bytes_left - 8'd1;
            if (bytes_left_next == 8'd0) begin
              phase_next = PH_CMD;
              fin        = captured;
            end
          end
          default: begin
            if (q_item.fill) begin
              res.action   = ACT_FORWARD;
              res.out_byte = q_item.data;
            end else begin
              cur_probe_next = q_item.probe;
              captured_next  = q_item.matmul || q_item.probe;
              if (!(q_item.matmul || q_item.probe)) begin
                res.action   = ACT_FORWARD;
                res.out_byte = q_item.data;
              end
              phase_next = PH_LEN;
            end
          end
        endcase
        if (fin) begin
          if (cur_probe) begin
            res.action = ACT_PROBE;
          end else if (hcount_next == HDR_SIZE) begin
            // The bulk start result waits for the dims pipeline.
            load      = 1'b0;
            wcnt_next = 2'd3;
          end else begin
            res.action = ACT_HDR_ERR;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && hdr_we) begin
      hdr[hcount[3:0]] <= q_item.data;
    end
    if (load) begin
      out_item <= res;
    end
    wlen     <= wlen_next;
    wblen    <= wblen_next;
    exp_m1   <= exp_m1_next;
    received <= received_next;
    sum      <= sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_CMD;
      captured     <= 1'b0;
      cur_probe    <= 1'b0;
      bytes_left   <= '0;
      hcount       <= '0;
      bulk_running <= 1'b0;
      dims_ok      <= 1'b0;
      wcnt         <= '0;
      out_valid    <= 1'b0;
    end else begin
      phase        <= phase_next;
      captured     <= captured_next;
      cur_probe    <= cur_probe_next;
      bytes_left   <= bytes_left_next;
      hcount       <= hcount_next;
      bulk_running <= bulk_running_next;
      dims_ok      <= dims_ok_next;
      wcnt         <= wcnt_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_pop_while_sizing: assert property (@(posedge clk) disable iff (rst)
    (wcnt != 2'd0) |-> !q_pop)
    else $error("queue popped while the dims pipeline was busy");

  a_start_opens_bulk: assert property (@(posedge clk) disable iff (rst)
    emit_start |=> bulk_running)
    else $error("bulk start did not open the bulk payload");

  a_store_region: assert property (@(posedge clk) disable iff (rst)
    (load && (res.action == ACT_STORE)) |-> (res.region != 2'd3))
    else $error("store routed to an unknown region");

endmodule

// ===== hw/rtl/host_frame_capture_parser.sv =====
// Top level of the host frame capture parser with its configuration registers.
//
// The parser takes one host link beat per cycle while the queue has room and
// returns exactly one result beat for each input beat, in order. Input beats
// are classified and held in a four-entry queue, so the input keeps flowing
// while the result register waits for the consumer. For the beat that
// completes a nine-byte matmul header, the bulk start result waits, and the
// queue is not popped, while the header products (K*N, M*K, M*N and the tile
// stream terms) and the cap compares run through a two-stage multiplier
// pipeline. The cap registers sit on an APB-style port at byte addresses 0, 4,
// 8 and 12 (weight, activation, bias and result caps); write them only while
// the parser is idle.
module host_frame_capture_parser import hfcp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  hfcp_in_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output hfcp_out_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  hfcp_caps_t  caps;
  logic        q_valid;
  logic        q_pop;
  hfcp_qitem_t q_item;
  reg_idx_t    reg_idx;
  logic        cfg_we;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite;

  // Cap registers; each keeps only its own width of the written word.
  always_ff @(posedge clk) begin
    if (rst) begin
      caps.weight_cap <= WEIGHT_CAP_RST;
      caps.act_cap    <= ACT_CAP_RST;
      caps.bias_cap   <= BIAS_CAP_RST;
      caps.out_cap    <= OUT_CAP_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_WEIGHT_CAP: caps.weight_cap <= pwdata[16:0];
        REG_ACT_CAP:    caps.act_cap    <= pwdata[14:0];
        REG_BIAS_CAP:   caps.bias_cap   <= pwdata[10:0];
        REG_OUT_CAP:    caps.out_cap    <= pwdata[15:0];
        default:        caps            <= caps;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WEIGHT_CAP: prdata = {15'd0, caps.weight_cap};
      REG_ACT_CAP:    prdata = {17'd0, caps.act_cap};
      REG_BIAS_CAP:   prdata = {21'd0, caps.bias_cap};
      REG_OUT_CAP:    prdata = {16'd0, caps.out_cap};
      default:        prdata = '0;
    endcase
  end

  // The front end decouples the link from the result consumer.
  hfcp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  // The back end owns all framing and bulk state and the result register.
  hfcp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .caps      (caps),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
